// File: sv/fft8_pkg.sv
`timescale 1ns / 1ps
package fft8_pkg;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int TWIDDLE_FRAC_DEF = 15;
   localparam int NPTS = 8;
   localparam int BIN_WIDTH = 20;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH_DEF-1:0] sample_real;
      logic signed [SAMPLE_WIDTH_DEF-1:0] sample_imag;
   } req_type;

   typedef struct packed {
      logic signed [BIN_WIDTH-1:0] bin_real;
      logic signed [BIN_WIDTH-1:0] bin_imag;
      logic                        last_bin;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_FILL, ST_LOAD, ST_S1, ST_S2, ST_S3, ST_EMIT
   } state_type;

   // cos(pi/4) in Q(f), rounded
   function automatic logic [17:0] cos_q(input int f);
      logic [63:0] t;
      t = 64'hB504F333F9DE6484 >> (63 - f);
      return 18'((t + 64'd1) >> 1);
   endfunction

   function automatic logic [2:0] bitrev3(input logic [2:0] i);
      return {i[0], i[1], i[2]};
   endfunction
endpackage

// File: sv/fft_8point_radix2.sv
`timescale 1ns / 1ps
// 8-point radix-2 DIT FFT. While busy is low, samples are taken one per cycle
// into an 8-entry store; after the eighth, busy stays high while the store is
// copied into a working memory in bit-reversed order, through three butterfly
// passes of four butterflies in three steps each (read, registered twiddle
// multiply, write back), and while the eight bins go out on consecutive cycles
// with rsp_strobe, last_bin on bin 7. Results cannot be stalled. Bins are
// unscaled 20-bit values.
module fft_8point_radix2 #(
   parameter int TWIDDLE_FRAC_BITS = fft8_pkg::TWIDDLE_FRAC_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fft8_pkg::req_type req_data,
   output logic              rsp_strobe,
   output fft8_pkg::rsp_type rsp_data
);
   localparam int BW = fft8_pkg::BIN_WIDTH;
   localparam int SAMPLE_WIDTH = fft8_pkg::SAMPLE_WIDTH_DEF;

   logic [2*SAMPLE_WIDTH-1:0] store [fft8_pkg::NPTS];
   logic signed [BW-1:0] wr_re [fft8_pkg::NPTS];
   logic signed [BW-1:0] wr_im [fft8_pkg::NPTS];

   fft8_pkg::state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] ph_ff, ph_in;
   logic [2*SAMPLE_WIDTH-1:0] srd_ff;
   logic signed [BW-1:0] ur_ff, ui_ff, vr_ff, vi_ff;
   logic signed [BW-1:0] bin_re_ff, bin_im_ff;
   logic [2:0] iu, iv;
   logic [1:0] tk;
   logic signed [BW-1:0] tr, ti;
   logic accept;

   assign accept = start && !busy;

   // butterfly index pairs per pass; cnt counts butterflies 0..3
   always_comb begin
      unique case (state_ff)
         fft8_pkg::ST_S1: begin iu = {cnt_ff[1:0], 1'b0}; tk = 2'd0; end
         fft8_pkg::ST_S2: begin iu = {cnt_ff[1], 1'b0, cnt_ff[0]}; tk = {cnt_ff[0], 1'b0}; end
         default:         begin iu = {1'b0, cnt_ff[1:0]}; tk = cnt_ff[1:0]; end
      endcase
      unique case (state_ff)
         fft8_pkg::ST_S1: iv = iu | 3'd1;
         fft8_pkg::ST_S2: iv = iu | 3'd2;
         default:         iv = iu | 3'd4;
      endcase
   end

   fft8_cmul #(.W(BW), .F(TWIDDLE_FRAC_BITS)) u_cmul (
      .clock(clock), .k(tk), .a(vr_ff), .b(vi_ff), .re(tr), .im(ti)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ph_in = ph_ff;
      unique case (state_ff)
         fft8_pkg::ST_FILL: if (accept) begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) state_in = fft8_pkg::ST_LOAD;
         end
         fft8_pkg::ST_LOAD: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd1) begin
               ph_in = 2'd0;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) state_in = fft8_pkg::ST_S1;
            end
         end
         fft8_pkg::ST_S1, fft8_pkg::ST_S2, fft8_pkg::ST_S3: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd2) begin
               ph_in = 2'd0;
               cnt_in = {1'b0, cnt_ff[1:0] + 2'd1};
               if (cnt_ff[1:0] == 2'd3) begin
                  cnt_in = 3'd0;
                  unique case (state_ff)
                     fft8_pkg::ST_S1: state_in = fft8_pkg::ST_S2;
                     fft8_pkg::ST_S2: state_in = fft8_pkg::ST_S3;
                     default:         state_in = fft8_pkg::ST_EMIT;
                  endcase
               end
            end
         end
         fft8_pkg::ST_EMIT: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) state_in = fft8_pkg::ST_FILL;
         end
         default: state_in = fft8_pkg::ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fft8_pkg::ST_FILL;
         cnt_ff <= 3'd0;
         ph_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ph_ff <= ph_in;
      end
   end

   // outputs
   always_comb begin
      busy = (state_ff != fft8_pkg::ST_FILL);
      rsp_strobe = (state_ff == fft8_pkg::ST_EMIT);
      rsp_data.bin_real = bin_re_ff;
      rsp_data.bin_imag = bin_im_ff;
      rsp_data.last_bin = (cnt_ff == 3'd7);
   end

   // sample store: write on accept, bit-reversed read during load
   always_ff @(posedge clock) begin
      if (accept)
         store[cnt_ff] <= {SAMPLE_WIDTH'(req_data.sample_imag),
                           SAMPLE_WIDTH'(req_data.sample_real)};
      srd_ff <= store[fft8_pkg::bitrev3(cnt_ff)];
   end

   // working memory: read u,v in phase 0, twiddle in phase 1, write back in phase 2
   always_ff @(posedge clock) begin
      if (state_ff == fft8_pkg::ST_LOAD && ph_ff == 2'd1) begin
         wr_re[cnt_ff] <= BW'(signed'(srd_ff[SAMPLE_WIDTH-1:0]));
         wr_im[cnt_ff] <= BW'(signed'(srd_ff[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
      end
      if (ph_ff == 2'd0) begin
         ur_ff <= wr_re[iu];
         ui_ff <= wr_im[iu];
         vr_ff <= wr_re[iv];
         vi_ff <= wr_im[iv];
      end
      if ((state_ff == fft8_pkg::ST_S1 || state_ff == fft8_pkg::ST_S2
           || state_ff == fft8_pkg::ST_S3) && ph_ff == 2'd2) begin
         wr_re[iu] <= ur_ff + tr;
         wr_im[iu] <= ui_ff + ti;
         wr_re[iv] <= ur_ff - tr;
         wr_im[iv] <= ui_ff - ti;
      end
      // bin read in the cycle before its beat; bin 0 is not written by the
      // final write-back of the final pass, so the early read is safe
      bin_re_ff <= wr_re[cnt_in];
      bin_im_ff <= wr_im[cnt_in];
   end
endmodule

// File: sv/fft8_cmul.sv
`timescale 1ns / 1ps
// Rotates (a,b) by W^k with per-product rounding; one multiply layer, registered.
module fft8_cmul #(
   parameter int W = 20,
   parameter int F = fft8_pkg::TWIDDLE_FRAC_DEF
) (
   input  logic                clock,
   input  logic [1:0]          k,
   input  logic signed [W-1:0] a,
   input  logic signed [W-1:0] b,
   output logic signed [W-1:0] re,
   output logic signed [W-1:0] im
);
   localparam int PW = W + F + 3;
   logic signed [F+2:0] c;
   logic signed [PW-1:0] pa_ff, pb_ff;
   logic signed [PW-1:0] pa_in, pb_in;
   logic [1:0] k_ff;
   logic signed [W-1:0] a_ff, b_ff;
   logic signed [PW-1:0] ra, rb, ran, rbn;

   assign c = (F+3)'(fft8_pkg::cos_q(F));
   assign pa_in = PW'(a) * PW'(c);
   assign pb_in = PW'(b) * PW'(c);

   always_ff @(posedge clock) begin
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      k_ff <= k;
      a_ff <= a;
      b_ff <= b;
   end

   // x*c and x*(-c) rounded separately; half-up rounding is not symmetric
   // W^1: (ra-rbn, ran+rb), W^3: (ran-rbn, ran+rbn)
   assign ra = (pa_ff + (PW'(1) <<< (F-1))) >>> F;
   assign rb = (pb_ff + (PW'(1) <<< (F-1))) >>> F;
   assign ran = ((PW'(1) <<< (F-1)) - pa_ff) >>> F;
   assign rbn = ((PW'(1) <<< (F-1)) - pb_ff) >>> F;

   always_comb begin
      case (k_ff)
         2'd0: begin re = a_ff; im = b_ff; end
         2'd1: begin re = W'(ra - rbn); im = W'(ran + rb); end
         2'd2: begin re = b_ff; im = -a_ff; end
         default: begin re = W'(ran - rbn); im = W'(ran + rbn); end
      endcase
   end
endmodule

// File: tb/fft_8point_radix2_tb.sv
`timescale 1ns / 1ps
module fft_8point_radix2_tb;
   localparam int COS_Q15 = 23170;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   fft8_pkg::req_type req_data;
   logic              rsp_strobe;
   fft8_pkg::rsp_type rsp_data;

   fft_8point_radix2 uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // predictor state
   logic signed [15:0] frame_re [8];
   logic signed [15:0] frame_im [8];
   int unsigned        frame_fill;
   fft8_pkg::rsp_type  bin_queue [$];
   int                 error_count;
   int                 bin_count;

   // typed-in bin 0 per directed frame, keyed by frame number
   logic signed [19:0] typed_re [int];
   logic signed [19:0] typed_im [int];

   // directed stimulus table; rows with has_exp carry a typed-in bin 0 for
   // the frame they complete
   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
      bit                 has_exp;
      logic signed [19:0] exp_re;
      logic signed [19:0] exp_im;
   } beat_type;
   beat_type directed_table [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic longint round_mul(input longint x, input longint w);
      longint v;
      v = x * w + 64'sd16384;
      return v >>> 15;
   endfunction

   task automatic rotate(input int k, inout longint re, inout longint im);
      longint a, b, wr, wi;
      a = re;
      b = im;
      case (k)
         0: return;
         2: begin
            re = b;
            im = -a;
            return;
         end
         1: begin
            wr = COS_Q15;
            wi = -COS_Q15;
         end
         default: begin
            wr = -COS_Q15;
            wi = -COS_Q15;
         end
      endcase
      re = round_mul(a, wr) - round_mul(b, wi);
      im = round_mul(a, wi) + round_mul(b, wr);
   endtask

   task automatic compute_bins();
      longint xr [8], xi [8], yr [8], yi [8], pr, pi;
      int order [8] = '{0, 4, 2, 6, 1, 5, 3, 7};
      fft8_pkg::rsp_type b;
      for (int i = 0; i < 8; i++) begin
         xr[i] = frame_re[order[i]];
         xi[i] = frame_im[order[i]];
      end
      for (int i = 0; i < 8; i += 2) begin
         yr[i] = xr[i] + xr[i+1];
         yi[i] = xi[i] + xi[i+1];
         yr[i+1] = xr[i] - xr[i+1];
         yi[i+1] = xi[i] - xi[i+1];
      end
      for (int i = 0; i < 8; i += 4) begin
         for (int j = 0; j < 2; j++) begin
            pr = yr[i+j+2];
            pi = yi[i+j+2];
            rotate(2 * j, pr, pi);
            xr[i+j] = yr[i+j] + pr;
            xi[i+j] = yi[i+j] + pi;
            xr[i+j+2] = yr[i+j] - pr;
            xi[i+j+2] = yi[i+j] - pi;
         end
      end
      for (int k = 0; k < 4; k++) begin
         pr = xr[k+4];
         pi = xi[k+4];
         rotate(k, pr, pi);
         yr[k] = xr[k] + pr;
         yi[k] = xi[k] + pi;
         yr[k+4] = xr[k] - pr;
         yi[k+4] = xi[k] - pi;
      end
      for (int k = 0; k < 8; k++) begin
         b.bin_real = yr[k][19:0];
         b.bin_imag = yi[k][19:0];
         b.last_bin = (k == 7);
         bin_queue.push_back(b);
      end
   endtask

   task automatic accept_sample(input logic signed [15:0] re, input logic signed [15:0] im);
      frame_re[frame_fill] = re;
      frame_im[frame_fill] = im;
      if (frame_fill == 7) begin
         frame_fill = 0;
         compute_bins();
      end else begin
         frame_fill++;
      end
   endtask

   // checker
   always @(posedge clock) begin
      fft8_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (bin_queue.size() == 0) begin
            report_mismatch("unexpected bin", 0, 0);
         end else begin
            want = bin_queue.pop_front();
            if (rsp_data.bin_real !== want.bin_real)
               report_mismatch("bin_real", rsp_data.bin_real, want.bin_real);
            if (rsp_data.bin_imag !== want.bin_imag)
               report_mismatch("bin_imag", rsp_data.bin_imag, want.bin_imag);
            if (rsp_data.last_bin !== want.last_bin)
               report_mismatch("last_bin", rsp_data.last_bin, want.last_bin);
         end
         if (bin_count % 8 == 0 && typed_re.exists(bin_count / 8)) begin
            if (rsp_data.bin_real !== typed_re[bin_count / 8])
               report_mismatch("typed bin_real", rsp_data.bin_real, typed_re[bin_count / 8]);
            if (rsp_data.bin_imag !== typed_im[bin_count / 8])
               report_mismatch("typed bin_imag", rsp_data.bin_imag, typed_im[bin_count / 8]);
         end
         bin_count++;
      end
   end

   logic idle_enable;

   // drive one beat; holds start across back-to-back beats
   task automatic send_beat(input logic signed [15:0] re, input logic signed [15:0] im);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{sample_real: re, sample_imag: im};
      @(posedge clock);
      while (busy) @(posedge clock);
      accept_sample(re, im);
   endtask

   task automatic add_row(input logic signed [15:0] re, input logic signed [15:0] im,
                          input bit has_exp, input logic signed [19:0] exp_re,
                          input logic signed [19:0] exp_im);
      beat_type t;
      t.re = re;
      t.im = im;
      t.has_exp = has_exp;
      t.exp_re = exp_re;
      t.exp_im = exp_im;
      directed_table.push_back(t);
   endtask

   // constant frame; bin 0 is eight times the sample
   task automatic add_frame(input logic signed [15:0] re, input logic signed [15:0] im,
                            input logic signed [19:0] dc_re, input logic signed [19:0] dc_im);
      for (int i = 0; i < 7; i++) add_row(re, im, 1'b0, 20'sd0, 20'sd0);
      add_row(re, im, 1'b1, dc_re, dc_im);
   endtask

   logic signed [15:0] r16, i16;
   int mode;

   initial begin
      error_count = 0;
      bin_count = 0;
      frame_fill = 0;
      start = 1'b0;
      req_data = '0;
      idle_enable = 1'b1;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: constant extremes, then an impulse (every bin equals the sample)
      add_frame(16'sh7fff, 16'sh8000, 20'sd262136, -20'sd262144);
      add_frame(16'sh8000, 16'sh7fff, -20'sd262144, 20'sd262136);
      add_row(16'sh7fff, 16'sh8000, 1'b0, 20'sd0, 20'sd0);
      for (int i = 1; i < 7; i++) add_row(16'sh0, 16'sh0, 1'b0, 20'sd0, 20'sd0);
      add_row(16'sh0, 16'sh0, 1'b1, 20'sd32767, -20'sd32768);
      foreach (directed_table[i]) begin
         if (directed_table[i].has_exp) begin
            typed_re[i / 8] = directed_table[i].exp_re;
            typed_im[i / 8] = directed_table[i].exp_im;
         end
         send_beat(directed_table[i].re, directed_table[i].im);
      end
      start <= 1'b0;
      @(posedge clock);
      wait (bin_queue.size() == 0);
      @(posedge clock);

      for (int n = 0; n < 306; n++) begin
         if (n == 150) begin
            // let everything drain before carrying on
            start <= 1'b0;
            @(posedge clock);
            while (bin_queue.size() != 0) @(posedge clock);
         end
         if (n == 240) idle_enable = 1'b0;
         mode = $urandom_range(0, 5);
         case (mode)
            0: begin
               r16 = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
               i16 = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            1: begin
               r16 = $signed(16'($urandom_range(0, 15))) - 16'sd8;
               i16 = $signed(16'($urandom_range(0, 15))) - 16'sd8;
            end
            default: begin
               r16 = 16'($urandom);
               i16 = 16'($urandom);
            end
         endcase
         send_beat(r16, i16);
      end
      // finish the partial frame so every sample lands in a result
      while (frame_fill != 0) send_beat(16'($urandom), 16'($urandom));
      start <= 1'b0;
      @(posedge clock);
      while (bin_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      if (error_count == 0 && bin_queue.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
